// File: rtl/pcd_pkg.sv
`timescale 1ns / 1ps
package pcd_pkg;

  localparam logic [31:0] CRC_POLY_REFL = 32'hEDB88320;
  localparam logic [31:0] CRC_ALL_ONES  = 32'hFFFFFFFF;
  localparam logic [30:0] MAX_LEN_RESET = 31'h7FFFFFFF;

  localparam logic [2:0] K_HEADER  = 3'd0;
  localparam logic [2:0] K_DATA    = 3'd1;
  localparam logic [2:0] K_CRCBYTE = 3'd2;
  localparam logic [2:0] K_OK      = 3'd3;
  localparam logic [2:0] K_CRCERR  = 3'd4;
  localparam logic [2:0] K_LENERR  = 3'd5;

  // op code decided by the front end
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [30:0] chunk_length;
    logic [31:0] chunk_kind;
    logic [7:0]  data_out;
    logic [2:0]  kind;
    logic        last;
  } result_t;

  // one byte of reflected crc-32, lsb first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/pcd_front.sv
`timescale 1ns / 1ps
module pcd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tuser,
  output logic          q_valid,
  output pcd_pkg::item_t q_item,
  input  logic          q_pop
);
  import pcd_pkg::*;

  item_t       slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  item_t       cls;

  // classify: restart drops the byte
  always_comb begin
    cls.op   = in_tuser ? OP_RESTART : OP_BYTE;
    cls.data = in_tuser ? 8'd0 : in_tdata;
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: rtl/pcd_back.sv
`timescale 1ns / 1ps
module pcd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  input  logic [30:0]     cfg_data,
  input  logic            q_valid,
  input  pcd_pkg::item_t  q_item,
  output logic            q_pop,
  output logic            res_valid,
  output pcd_pkg::result_t res,
  input  logic            res_ready
);
  import pcd_pkg::*;

  localparam logic [1:0] PH_LENGTH = 2'd0;
  localparam logic [1:0] PH_TYPE   = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_CRC    = 2'd3;

  logic [30:0] max_len_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] len_r, len_nxt;
  logic [30:0] left_r, left_nxt;
  logic [31:0] type_r, type_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] rx_r, rx_nxt;
  logic        halt_r, halt_nxt;
  logic        valid_r;
  result_t     res_r, res_nxt;
  logic [31:0] len_base;
  logic [31:0] crc_upd;
  logic [7:0]  b;

  assign q_pop     = q_valid && (!valid_r || res_ready);
  assign res_valid = valid_r;
  assign res       = res_r;
  assign b         = q_item.data;
  assign crc_upd   = crc32_byte(crc_r, b);
  assign len_base  = (idx_r == 2'd0) ? 32'd0 : len_r;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    type_nxt  = type_r;
    crc_nxt   = crc_r;
    rx_nxt    = rx_r;
    halt_nxt  = halt_r;
    res_nxt.kind     = K_HEADER;
    res_nxt.data_out = 8'd0;
    res_nxt.last     = 1'b0;
    if (q_item.op == OP_RESTART) begin
      phase_nxt = PH_LENGTH;
      idx_nxt   = 2'd0;
      len_nxt   = 32'd0;
      left_nxt  = 31'd0;
      type_nxt  = 32'd0;
      crc_nxt   = CRC_ALL_ONES;
      rx_nxt    = 32'd0;
      halt_nxt  = 1'b0;
    end else if (halt_r) begin
      res_nxt.kind = K_LENERR;
    end else begin
      unique case (phase_r)
        PH_LENGTH: begin
          if (idx_r == 2'd0) begin
            type_nxt = 32'd0;
            rx_nxt   = 32'd0;
            crc_nxt  = CRC_ALL_ONES;
          end
          len_nxt = {len_base[23:0], b};
          if (idx_r == 2'd3) begin
            idx_nxt = 2'd0;
            if (len_nxt > {1'b0, max_len_r}) begin
              res_nxt.kind = K_LENERR;
              res_nxt.last = 1'b1;
              halt_nxt     = 1'b1;
            end else begin
              phase_nxt = PH_TYPE;
            end
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
        PH_TYPE: begin
          type_nxt = {type_r[23:0], b};
          crc_nxt  = crc_upd;
          if (idx_r == 2'd3) begin
            idx_nxt   = 2'd0;
            left_nxt  = len_r[30:0];
            phase_nxt = (len_r[30:0] == 31'd0) ? PH_CRC : PH_DATA;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
        PH_DATA: begin
          res_nxt.kind     = K_DATA;
          res_nxt.data_out = b;
          crc_nxt          = crc_upd;
          left_nxt         = left_r - 31'd1;
          if (left_nxt == 31'd0) begin
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          rx_nxt = {rx_r[23:0], b};
          if (idx_r == 2'd3) begin
            idx_nxt      = 2'd0;
            res_nxt.kind = (rx_nxt == ~crc_r) ? K_OK : K_CRCERR;
            res_nxt.last = 1'b1;
            phase_nxt    = PH_LENGTH;
          end else begin
            res_nxt.kind = K_CRCBYTE;
            idx_nxt      = idx_r + 2'd1;
          end
        end
      endcase
    end
    res_nxt.chunk_kind   = type_nxt;
    res_nxt.chunk_length = len_nxt[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
      phase_r   <= PH_LENGTH;
      idx_r     <= 2'd0;
      len_r     <= 32'd0;
      left_r    <= 31'd0;
      type_r    <= 32'd0;
      crc_r     <= CRC_ALL_ONES;
      rx_r      <= 32'd0;
      halt_r    <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_len_r <= cfg_data;
      end
      if (q_pop) begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        len_r   <= len_nxt;
        left_r  <= left_nxt;
        type_r  <= type_nxt;
        crc_r   <= crc_nxt;
        rx_r    <= rx_nxt;
        halt_r  <= halt_nxt;
        valid_r <= 1'b1;
      end else if (res_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

// File: rtl/png_chunk_deframer_crc32.sv
`timescale 1ns / 1ps
// png chunk deframer with crc-32 check. every accepted byte item gives exactly one
// result item: its class (header, data, crc byte, chunk ok, crc error, length error),
// the data byte, and the chunk type and length seen so far. the reflected crc-32
// runs over type and data bytes and is checked on the fourth crc byte. a length above
// max_chunk_length reports a length error and halts until an item with restart set.
// throughput is one item per clock while out_tready is high: the crc update is a
// byte-wide xor network in the parser stage, and a two-entry queue plus an output
// register separate the ports. an accepted item is written into the queue and is
// then popped into the output register that drives the result.
// cfg writes are always taken and should only happen while the block is idle.
module png_chunk_deframer_crc32 (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: max_chunk_length
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tuser,   // [0] restart
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] data_out, [39:8] chunk_kind,
                                  // [70:40] chunk_length, [71] zero
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast
);
  import pcd_pkg::*;

  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  result_t res;

  assign cfg_ready = 1'b1;

  // front end: accepts items, tags restart, buffers two entries
  pcd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // back end: chunk parser, crc and output register
  pcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  assign out_tdata = {1'b0, res.chunk_length, res.chunk_kind, res.data_out};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

  // last only closes a chunk with a verdict
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      (out_tuser == K_OK) || (out_tuser == K_CRCERR) || (out_tuser == K_LENERR))
    else $error("last on a non-terminal kind");

  // data byte is zero except on data items
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != K_DATA) |-> (out_tdata[7:0] == 8'd0))
    else $error("data_out nonzero outside data item");

  // kind never takes an unused code
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != 3'd6) && (out_tuser != 3'd7))
    else $error("illegal kind code");

endmodule
